// ----- design/lcs_pkg.sv -----
// Shared types, constants and helpers for the LCD character segment writer.
// Holds the glyph table, the opcode codes and the segment address map.
// No dependencies; the encoder, the RAM and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package lcs_pkg;

  // Command opcodes carried in the opcode field.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Character range that the glyph table covers, both ends included.
  localparam logic [7:0] FIRST_CODE = 8'h30;
  localparam logic [7:0] LAST_CODE  = 8'h5A;
  localparam int         GLYPHS     = 43;

  // Pattern bits forced by the colon and decimal point flags.
  localparam logic [15:0] COLON_BIT = 16'h0020;
  localparam logic [15:0] POINT_BIT = 16'h0002;

  // Bit distance between two commons in the display RAM.
  localparam int COMMON_STRIDE = 28;

  // Width of a RAM bit address and of a byte index taken from it.
  localparam int BIT_ADDR_W = 7;
  localparam int BYTE_W     = 4;

  // Segment numbers of the four map slots at digit position zero.
  localparam logic [4:0] SLOT_BASE [4] = '{5'd0, 5'd1, 5'd22, 5'd23};

  // Fourteen-segment patterns for codes FIRST_CODE through LAST_CODE.
  localparam logic [15:0] GLYPH_TABLE [GLYPHS] = '{
    16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00, 16'hAF00, 16'hBF00,
    16'h4600, 16'hFF00, 16'hEF00,
    16'h0044, 16'hA000, 16'h0002, 16'h80DD, 16'h0000, 16'h0000, 16'h0000,
    16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
    16'hFA00, 16'h0011, 16'h5300, 16'h9844, 16'h1900, 16'h5A42, 16'h5A06,
    16'h5F00, 16'hFC00, 16'h5F04, 16'hFC04, 16'hAF00, 16'h0414, 16'h5B00,
    16'h18C0, 16'h5A84, 16'h00C9, 16'h0058, 16'h05C0
  };

  // Request from the sequencer to the display RAM for one cycle.
  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              we;
    logic [BYTE_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } ram_req_t;

  // RAM bit address for pattern step (common in the upper two bits, map
  // slot in the lower two) at the given digit position.
  function automatic logic [BIT_ADDR_W-1:0] bit_addr(input logic [3:0] step,
                                                     input logic [2:0] pos);
    logic [1:0] z;
    logic [1:0] slot;
    logic [4:0] two_pos;
    logic [4:0] seg;
    z       = step[3:2];
    slot    = step[1:0];
    two_pos = {1'b0, pos, 1'b0};
    // The upper two slots count down with the position, the lower two up.
    if (slot[1]) begin
      seg = SLOT_BASE[slot] - two_pos;
    end else begin
      seg = SLOT_BASE[slot] + two_pos;
    end
    return BIT_ADDR_W'(z) * BIT_ADDR_W'(COMMON_STRIDE) + BIT_ADDR_W'(seg);
  endfunction

endpackage

// ----- design/lcs_cmd_if.sv -----
// Command channel of the LCD character segment writer: valid, ready, payload.
// Depends on nothing but the widths of the command fields.
`timescale 1ns / 1ps

interface lcs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic       decimal_point;
  logic       colon_on;
  logic [2:0] digit_position;
  logic [3:0] byte_index;

  modport source (
    output valid, opcode, char_code, decimal_point, colon_on, digit_position,
           byte_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, char_code, decimal_point, colon_on, digit_position,
           byte_index,
    output ready
  );
endinterface

// ----- design/lcs_rsp_if.sv -----
// Response channel of the LCD character segment writer: valid, ready, payload.
// Depends on nothing but the widths of the response fields.
`timescale 1ns / 1ps

interface lcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] segment_pattern;
  logic [7:0]  read_byte;

  modport source (
    output valid, segment_pattern, read_byte,
    input  ready
  );

  modport sink (
    input  valid, segment_pattern, read_byte,
    output ready
  );
endinterface

// ----- design/lcs_encoder.sv -----
// Character encoder: maps an ASCII code and the two flags to a 16-bit pattern.
// Uses the glyph table and flag constants of lcs_pkg.
`timescale 1ns / 1ps

module lcs_encoder (
  input  logic [7:0]  char_code,
  input  logic        decimal_point,
  input  logic        colon_on,
  output logic [15:0] pattern
);

  logic [7:0]  offset;
  logic        in_range;
  logic [15:0] glyph;

  // Look the code up in the table; codes outside the range are blank.
  assign offset   = char_code - lcs_pkg::FIRST_CODE;
  assign in_range = (char_code >= lcs_pkg::FIRST_CODE) &&
                    (char_code <= lcs_pkg::LAST_CODE);
  assign glyph    = in_range ? lcs_pkg::GLYPH_TABLE[offset[5:0]] : 16'h0000;

  // The flags light their segments on top of the glyph.
  assign pattern = glyph
                 | (colon_on      ? lcs_pkg::COLON_BIT : 16'h0000)
                 | (decimal_point ? lcs_pkg::POINT_BIT : 16'h0000);

endmodule

// ----- design/lcs_ram.sv -----
// Display RAM: one byte-wide synchronous memory with registered read data.
// Per-entry valid bits let reset and the clear command empty it without writing the data array.
// Depends on lcs_pkg for the request struct.
`timescale 1ns / 1ps

module lcs_ram #(
  parameter int RAM_BYTES = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  lcs_pkg::ram_req_t req,
  output logic [7:0]        rd_data
);

  localparam int AW = $clog2(RAM_BYTES);

  logic [7:0]           mem [RAM_BYTES];
  logic [RAM_BYTES-1:0] valid;
  logic                 rd_ok;
  logic                 wr_ok;

  assign rd_ok = int'(req.rd_addr) < RAM_BYTES;
  assign wr_ok = int'(req.wr_addr) < RAM_BYTES;

  // Data array write port.
  always_ff @(posedge clk) begin
    if (req.we && wr_ok) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // Valid bits: cleared by reset and the clear command, set by a write.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.we && wr_ok) begin
      valid[req.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  // Registered read; an entry never written since a clear reads as zero.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      if (rd_ok && valid[req.rd_addr[AW-1:0]]) begin
        rd_data <= mem[req.rd_addr[AW-1:0]];
      end else begin
        rd_data <= 8'h00;
      end
    end
  end

endmodule

// ----- design/lcd_char_segment_writer.sv -----
// Top level of the LCD character segment writer: command sequencer,
// read-modify-write pipeline and output register.
// Depends on lcs_pkg, lcs_cmd_if, lcs_rsp_if, lcs_encoder and lcs_ram.
`timescale 1ns / 1ps

// Usage: each word on cmd is one command. A write command turns char_code and
// the two flags into a 16-bit segment pattern and stores its sixteen bits into
// the display RAM at the given digit position. A clear command empties the
// RAM; a read command returns one RAM byte. Every command gives exactly one
// word on rsp: the pattern for a write, the byte for a read, zeros otherwise.
// A write walks the sixteen pattern bits, one RAM read-modify-write per bit,
// overlapped so that the read of one bit meets the write of the previous one;
// a write of the byte just written is forwarded. cmd.ready is high only
// between commands, and one command is in progress at a time. rsp is
// registered: the next command is accepted while a finished response word
// still waits; if the receiver stalls with a word held, the following
// command waits finished until rsp is free. Reset (rst, synchronous)
// empties the RAM and drops rsp.valid.

module lcd_char_segment_writer #(
  parameter int RAM_BYTES = 14
) (
  input logic      clk,
  input logic      rst,
  lcs_cmd_if.sink  cmd,
  lcs_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [4:0]                 step;
  logic [15:0]                pattern;
  logic [2:0]                 pos;
  logic [15:0]                res_pat;
  logic [7:0]                 res_byte;
  logic                       wr_pend;
  logic [lcs_pkg::BIT_ADDR_W-1:0] wr_addr;
  logic                       wr_val;
  logic                       last_we;
  logic [lcs_pkg::BYTE_W-1:0] last_byte;
  logic [7:0]                 last_data;
  logic [15:0]                enc_pattern;
  logic [lcs_pkg::BIT_ADDR_W-1:0] issue_addr;
  logic                       issue;
  logic [lcs_pkg::BYTE_W-1:0] wr_byte;
  logic [7:0]                 old_byte;
  logic [7:0]                 new_byte;
  logic [7:0]                 ram_rdata;
  logic                       accept;
  logic                       rsp_free;
  lcs_pkg::ram_req_t          ram_req;

  lcs_encoder u_encoder (
    .char_code     (cmd.char_code),
    .decimal_point (cmd.decimal_point),
    .colon_on      (cmd.colon_on),
    .pattern       (enc_pattern)
  );

  lcs_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;

  // Read stage: one pattern bit per cycle until all sixteen are issued.
  assign issue      = (state == ST_WRITE) && !step[4];
  assign issue_addr = lcs_pkg::bit_addr(step[3:0], pos);

  // Modify stage: take the byte just written when the read raced that write.
  assign wr_byte = wr_addr[lcs_pkg::BIT_ADDR_W-1:3];
  always_comb begin
    if (last_we && (last_byte == wr_byte)) begin
      old_byte = last_data;
    end else begin
      old_byte = ram_rdata;
    end
    new_byte              = old_byte;
    new_byte[wr_addr[2:0]] = wr_val;
  end

  // RAM request for this cycle.
  always_comb begin
    ram_req         = '0;
    ram_req.clear   = accept && (cmd.opcode == lcs_pkg::OP_CLEAR);
    ram_req.we      = wr_pend;
    ram_req.wr_addr = wr_byte;
    ram_req.wr_data = new_byte;
    if (issue) begin
      ram_req.rd_en   = 1'b1;
      ram_req.rd_addr = issue_addr[lcs_pkg::BIT_ADDR_W-1:3];
    end else if (accept && (cmd.opcode == lcs_pkg::OP_READ)) begin
      ram_req.rd_en   = 1'b1;
      ram_req.rd_addr = cmd.byte_index;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (cmd.opcode == lcs_pkg::OP_WRITE) begin
            state_next = ST_WRITE;
          end else if (cmd.opcode == lcs_pkg::OP_READ) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        if (step[4] && !wr_pend) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wr_pend <= 1'b0;
      last_we <= 1'b0;
      step    <= '0;
    end else begin
      state   <= state_next;
      wr_pend <= issue;
      last_we <= ram_req.we;
      if (accept) begin
        step <= '0;
      end else if (issue) begin
        step <= step + 5'd1;
      end
    end
  end

  // Command payload, pipeline payload and the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      pattern  <= enc_pattern;
      pos      <= cmd.digit_position;
      res_byte <= 8'h00;
      if (cmd.opcode == lcs_pkg::OP_WRITE) begin
        res_pat <= enc_pattern;
      end else begin
        res_pat <= 16'h0000;
      end
    end
    if (state == ST_READ) begin
      res_byte <= ram_rdata;
    end
    if (issue) begin
      wr_addr <= issue_addr;
      wr_val  <= pattern[{~step[3:2], step[1:0]}];
    end
    last_byte <= wr_byte;
    last_data <= new_byte;
  end

  // Output register toward the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == ST_DONE) && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && rsp_free) begin
      rsp.segment_pattern <= res_pat;
      rsp.read_byte       <= res_byte;
    end
  end

`ifndef SYNTH
  // The RAM is written only by the bit pipeline of a write command.
  a_write_only_in_write: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (state == ST_WRITE))
    else $error("display RAM written outside a write command");

  // A clear command finishes in the following cycle.
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.opcode == lcs_pkg::OP_CLEAR)) |=> (state == ST_DONE))
    else $error("clear command did not complete at once");

  // A new response word is loaded only from a finished command.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !$past(rsp.valid)) |-> ($past(state) == ST_DONE))
    else $error("response word appeared without a finished command");

  // The step counter stops after the sixteenth pattern bit.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step[4] |-> (step[3:0] == 4'd0))
    else $error("pattern step counter ran past sixteen");
`endif

endmodule

// ----- dv/lcs_ram_scoreboard.sv -----
// Scoreboard for the LCD character segment writer: watches both channels,
// keeps a shadow copy of the display RAM and checks every response word.
// Depends on lcs_pkg, lcs_cmd_if and lcs_rsp_if.
`timescale 1ns / 1ps

module lcs_ram_scoreboard #(
  parameter int RAM_BYTES = 14
) (
  input  logic clk,
  input  logic rst,
  lcs_cmd_if   cmd,
  lcs_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  import lcs_pkg::*;

  typedef struct packed {
    logic [15:0] segment_pattern;
    logic [7:0]  read_byte;
  } rsp_word_t;

  // Fourteen-segment shapes for '0' through 'Z', kept apart from the design's copy.
  localparam logic [15:0] GLYPH_ROM [43] = '{
    16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEA00, 16'hAF00, 16'hBF00,
    16'h4600, 16'hFF00, 16'hEF00,
    16'h0044, 16'hA000, 16'h0002, 16'h80DD, 16'h0000, 16'h0000, 16'h0000,
    16'hFE00, 16'h6714, 16'h1D00, 16'h4714, 16'h9D00, 16'h9C00, 16'h3F00,
    16'hFA00, 16'h0011, 16'h5300, 16'h9844, 16'h1900, 16'h5A42, 16'h5A06,
    16'h5F00, 16'hFC00, 16'h5F04, 16'hFC04, 16'hAF00, 16'h0414, 16'h5B00,
    16'h18C0, 16'h5A84, 16'h00C9, 16'h0058, 16'h05C0
  };

  // Segment numbers of the four map slots at digit position zero.
  localparam int SEG_BASE [4] = '{0, 1, 22, 23};

  logic [7:0] shadow_ram [RAM_BYTES];
  rsp_word_t  pending_rsp [$];

  // Pattern for one character with the colon and point flags merged in.
  function automatic logic [15:0] glyph_pattern(input logic [7:0] code,
                                                input logic dp,
                                                input logic col);
    logic [15:0] pat;
    pat = '0;
    if (code >= FIRST_CODE && code <= LAST_CODE) begin
      pat = GLYPH_ROM[code - FIRST_CODE];
    end
    if (col) begin
      pat = pat | COLON_BIT;
    end
    if (dp) begin
      pat = pat | POINT_BIT;
    end
    return pat;
  endfunction

  // Scatter the sixteen pattern bits over the four commons of one digit.
  function automatic void paint_digit(input logic [15:0] pat, input logic [2:0] pos);
    int seg;
    int addr;
    for (int z = 0; z < 4; z++) begin
      for (int i = 0; i < 4; i++) begin
        if (i < 2) begin
          seg = SEG_BASE[i] + 2 * int'(pos);
        end else begin
          seg = SEG_BASE[i] - 2 * int'(pos);
        end
        addr = COMMON_STRIDE * z + seg;
        if (addr / 8 < RAM_BYTES) begin
          shadow_ram[addr / 8][addr % 8] = pat[12 - 4 * z + i];
        end
      end
    end
  endfunction

  // Apply one command to the shadow RAM and return the word it should produce.
  function automatic rsp_word_t shadow_command(input logic [1:0] op,
                                               input logic [7:0] code,
                                               input logic dp,
                                               input logic col,
                                               input logic [2:0] pos,
                                               input logic [3:0] idx);
    rsp_word_t w;
    w = '0;
    case (op)
      OP_WRITE: begin
        w.segment_pattern = glyph_pattern(code, dp, col);
        paint_digit(w.segment_pattern, pos);
      end
      OP_CLEAR: begin
        foreach (shadow_ram[b]) shadow_ram[b] = '0;
      end
      OP_READ: begin
        if (int'(idx) < RAM_BYTES) begin
          w.read_byte = shadow_ram[idx];
        end
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Compare each response word with the oldest prediction, then log new commands.
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      foreach (shadow_ram[b]) shadow_ram[b] = '0;
      pending_rsp.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          $error("unexpected word: segment_pattern %h read_byte %h",
                 rsp.segment_pattern, rsp.read_byte);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.segment_pattern !== want.segment_pattern) begin
            mismatches++;
            $error("segment_pattern: expected %h, got %h",
                   want.segment_pattern, rsp.segment_pattern);
          end
          if (rsp.read_byte !== want.read_byte) begin
            mismatches++;
            $error("read_byte: expected %h, got %h", want.read_byte, rsp.read_byte);
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        pending_rsp.push_back(shadow_command(cmd.opcode, cmd.char_code,
                                             cmd.decimal_point, cmd.colon_on,
                                             cmd.digit_position, cmd.byte_index));
      end
    end
    outstanding <= pending_rsp.size();
  end

endmodule

// ----- dv/tb.sv -----
// Top of the LCD character segment writer testbench: clock, reset, command
// stimulus, response back-pressure and the final verdict.
// Depends on lcs_pkg, lcs_cmd_if, lcs_rsp_if, lcs_ram_scoreboard and the design.
`timescale 1ns / 1ps

module tb;
  import lcs_pkg::*;

  localparam int         RAM_BYTES    = 14;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 650;
  localparam int         BLOCK_ITEMS  = 50;
  localparam int         LONG_HOLD    = 300;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         CYCLE_LIMIT  = 500000;

  logic clk;
  logic rst;
  bit   quiet;
  bit   hold_request;
  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;

  lcs_cmd_if cmd_ch ();
  lcs_rsp_if rsp_ch ();

  lcd_char_segment_writer #(
    .RAM_BYTES(RAM_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  lcs_ram_scoreboard #(
    .RAM_BYTES(RAM_BYTES)
  ) u_scoreboard (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offer one command word and hold it until the block takes it.
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] code,
                          input logic dp, input logic col,
                          input logic [2:0] pos, input logic [3:0] idx);
    int gap;
    cmd_ch.valid          <= 1'b1;
    cmd_ch.opcode         <= op;
    cmd_ch.char_code      <= code;
    cmd_ch.decimal_point  <= dp;
    cmd_ch.colon_on       <= col;
    cmd_ch.digit_position <= pos;
    cmd_ch.byte_index     <= idx;
    do @(posedge clk); while (!cmd_ch.ready);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random command, weighted toward well-formed writes and reads.
  task automatic send_random();
    int         r;
    logic [1:0] op;
    logic [7:0] code;
    logic [2:0] pos;
    logic [3:0] idx;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      op = OP_WRITE;
    end else if (r < 90) begin
      op = OP_READ;
    end else if (r < 95) begin
      op = OP_CLEAR;
    end else begin
      op = OP_UNUSED;
    end
    code = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(FIRST_CODE, LAST_CODE))
                                        : 8'($urandom_range(0, 255));
    pos  = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(0, 7));
    idx  = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, RAM_BYTES - 1))
                                       : 4'($urandom_range(0, 15));
    send_cmd(op, code, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pos, idx);
  endtask

  // Response side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 2) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Command stimulus and verdict.
  initial begin
    rst                   <= 1'b1;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.opcode         <= OP_WRITE;
    cmd_ch.char_code      <= '0;
    cmd_ch.decimal_point  <= 1'b0;
    cmd_ch.colon_on       <= 1'b0;
    cmd_ch.digit_position <= '0;
    cmd_ch.byte_index     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Table ends, codes just outside it, both flags, every position.
    send_cmd(OP_WRITE, 8'h30, 1'b1, 1'b0, 3'd0, 4'd15);
    send_cmd(OP_WRITE, 8'h5A, 1'b0, 1'b1, 3'd5, 4'd0);
    send_cmd(OP_WRITE, 8'h2F, 1'b1, 1'b1, 3'd1, 4'd7);
    send_cmd(OP_WRITE, 8'h5B, 1'b0, 1'b0, 3'd2, 4'd8);
    send_cmd(OP_WRITE, 8'h00, 1'b1, 1'b1, 3'd3, 4'd0);
    send_cmd(OP_WRITE, 8'hFF, 1'b1, 1'b1, 3'd4, 4'd15);
    // Positions six and seven land on other digits' bits.
    send_cmd(OP_WRITE, 8'h38, 1'b1, 1'b1, 3'd6, 4'd0);
    send_cmd(OP_WRITE, 8'h4D, 1'b0, 1'b1, 3'd7, 4'd0);
    // Read back, including indexes past the end of the RAM.
    send_cmd(OP_READ, 8'hFF, 1'b1, 1'b1, 3'd7, 4'd0);
    send_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 3'd0, 4'd6);
    send_cmd(OP_READ, 8'h41, 1'b1, 1'b0, 3'd2, 4'd13);
    send_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 3'd0, 4'd14);
    send_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 3'd0, 4'd15);
    // The unused opcode must leave the RAM alone.
    send_cmd(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 3'd7, 4'd15);
    send_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 3'd0, 4'd13);
    send_cmd(OP_CLEAR, 8'hFF, 1'b1, 1'b1, 3'd7, 4'd15);
    send_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 3'd0, 4'd0);
    send_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 3'd0, 4'd13);
    send_cmd(OP_WRITE, 8'h3B, 1'b0, 1'b0, 3'd0, 4'd0);
    send_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 3'd0, 4'd1);

    // Random blocks; one runs against a long receiver hold-off, one starts drained.
    for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
      quiet = (blk == 2) || ($urandom_range(0, 3) == 0);
      if (blk == 2) begin
        hold_request = 1'b1;
      end
      if (blk == 6) begin
        wait_idle();
      end
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        send_random();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
